### rtl/core/smme_pkg.sv
// ----------------------------------------------------------------------------
// smme_pkg: shared definitions for the stereo min/max envelope
// Widths, configuration register indexes and the status of the remainder unit.
// ----------------------------------------------------------------------------
package smme_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAX_W      = 15;
    localparam int FRAMES_W   = 24;
    localparam int STRIDE_W   = 8;
    localparam int BPV_W      = 16;
    localparam int BUCKET_W   = 16;
    localparam int FCNT_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 80;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUCKET_FRAMES    = 2'd0,
        CFG_PIXEL_STRIDE     = 2'd1,
        CFG_BUCKETS_PER_VIEW = 2'd2
    } t_cfg_idx;

    // Status of the bit-serial remainder unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_stat;

endpackage

### rtl/core/stereo_min_max_envelope.sv
// ----------------------------------------------------------------------------
// stereo_min_max_envelope: min/max envelope of a stereo 16-bit stream
// Groups frames into buckets and emits per-channel min and max per bucket.
// ----------------------------------------------------------------------------
// The frame that closes a result word passes the input register, then the
// output register. Throughput: one input word per cycle unless the output
// stalls, set by the single-pass update stage. After any configuration
// write the input stalls while the bucket size is rebuilt and the stride
// phase is recomputed by the bit-serial remainder unit (one bit of the
// frame counter per cycle). Reset is synchronous and active low; it clears the
// envelope and valid state and sets the configuration and bucket size to 1.
// ----------------------------------------------------------------------------
module stereo_min_max_envelope (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Slave side, tdata: left_sample [15:0], right_sample [31:16]
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [smme_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // tuser: start_view [0], end_of_data [1]
    input  logic [smme_pkg::S_TUSER_W-1:0]     i_s_tuser,
    // Master side, tdata: left_min [15:0], left_max [30:16], right_min [46:31],
    // right_max [61:47], bucket_index [77:62], zero fill [79:78]
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [smme_pkg::M_TDATA_W-1:0]     o_m_tdata,
    output logic                               o_m_tlast,
    // Configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [smme_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [smme_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import smme_pkg::*;

    // Configuration registers, kept in their low bits. A zero acts as one.
    logic [FRAMES_W-1:0] r_bucket_frames;
    logic [STRIDE_W-1:0] r_pixel_stride;
    logic [BPV_W-1:0]    r_bpv;
    logic [FRAMES_W-1:0] eff_frames;
    logic [STRIDE_W-1:0] eff_stride;
    logic [BPV_W-1:0]    eff_bpv;

    // Bucket size is a registered product, rebuilt after each write.
    logic [FCNT_W-1:0]   r_size;
    logic                r_recalc;
    logic                cfg_wr;

    // Remainder unit recovers the stride phase from the frame counter.
    t_mod_stat           mod_stat;
    logic [STRIDE_W-1:0] mod_rem;

    // Input register.
    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_in_l;
    logic [SAMPLE_W-1:0] r_in_r;
    logic                r_in_start;
    logic                r_in_eod;

    // Envelope state. Minimums never exceed zero and maximums are never
    // below zero, so the maximums are kept without their sign bit.
    logic signed [SAMPLE_W-1:0] r_lmin, r_rmin;
    logic [MAX_W-1:0]    r_lmax, r_rmax;
    logic [FCNT_W-1:0]   r_fcnt;
    logic [STRIDE_W-1:0] r_phase;
    logic [BUCKET_W-1:0] r_bucket;
    logic                r_done;

    // Output register.
    logic                r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic                r_out_last;

    // Update stage signals.
    logic                adv;
    logic                fire;
    logic                s_accept;
    logic signed [SAMPLE_W-1:0] s_l, s_r;
    logic signed [SAMPLE_W-1:0] c_lmin, c_rmin, u_lmin, u_rmin;
    logic [MAX_W-1:0]    c_lmax, c_rmax, u_lmax, u_rmax;
    logic [FCNT_W-1:0]   c_fcnt;
    logic [STRIDE_W-1:0] c_phase;
    logic [BUCKET_W-1:0] c_bucket;
    logic                c_done;
    logic [FCNT_W:0]     fcnt_inc;
    logic [STRIDE_W:0]   phase_inc;
    logic [BUCKET_W:0]   bucket_inc;
    logic signed [SAMPLE_W-1:0] n_lmin, n_rmin;
    logic [MAX_W-1:0]    n_lmax, n_rmax;
    logic [FCNT_W-1:0]   n_fcnt;
    logic [STRIDE_W-1:0] n_phase;
    logic [BUCKET_W-1:0] n_bucket;
    logic                n_done;
    logic                n_emit;
    logic                n_last;
    logic [M_TDATA_W-1:0] n_out_data;

    assign eff_frames = (r_bucket_frames == '0) ? FRAMES_W'(1) : r_bucket_frames;
    assign eff_stride = (r_pixel_stride == '0) ? STRIDE_W'(1) : r_pixel_stride;
    assign eff_bpv    = (r_bpv == '0) ? BPV_W'(1) : r_bpv;

    // Config port always open; users must write only while idle (not enforced).
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    // The update stage moves whenever the output register is free or drained.
    assign adv        = !r_out_valid || i_m_tready;
    assign fire       = r_in_valid && adv;
    assign o_s_tready = !r_recalc && !mod_stat.busy && (!r_in_valid || adv);
    assign s_accept   = i_s_tvalid && o_s_tready;

    smme_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_recalc && !cfg_wr),
        .i_dividend (r_fcnt),
        .i_divisor  (eff_stride),
        .o_stat     (mod_stat),
        .o_rem      (mod_rem)
    );

    // Configuration registers and the derived bucket size.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_frames <= FRAMES_W'(1);
            r_pixel_stride  <= STRIDE_W'(1);
            r_bpv           <= BPV_W'(1);
            r_size          <= FCNT_W'(1);
            r_recalc        <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_recalc <= 1'b1;
                unique case (i_cfg_index)
                    CFG_BUCKET_FRAMES:    r_bucket_frames <= i_cfg_data;
                    CFG_PIXEL_STRIDE:     r_pixel_stride  <= i_cfg_data[STRIDE_W-1:0];
                    CFG_BUCKETS_PER_VIEW: r_bpv           <= i_cfg_data[BPV_W-1:0];
                    default: ;
                endcase
            end else if (r_recalc) begin
                r_recalc <= 1'b0;
                r_size   <= FCNT_W'(eff_frames) * FCNT_W'(eff_stride);
            end
        end
    end

    // Single-pass update: a start item clears the view first, then the frame
    // is folded in, closing a full bucket, or end of data closes a partial one.
    always_comb begin
        s_l = signed'(r_in_l);
        s_r = signed'(r_in_r);

        c_lmin   = r_in_start ? '0 : r_lmin;
        c_rmin   = r_in_start ? '0 : r_rmin;
        c_lmax   = r_in_start ? '0 : r_lmax;
        c_rmax   = r_in_start ? '0 : r_rmax;
        c_fcnt   = r_in_start ? '0 : r_fcnt;
        c_phase  = r_in_start ? '0 : r_phase;
        c_bucket = r_in_start ? '0 : r_bucket;
        c_done   = r_in_start ? 1'b0 : r_done;

        // Only the frames at stride phase zero are examined.
        u_lmin = c_lmin;
        u_rmin = c_rmin;
        u_lmax = c_lmax;
        u_rmax = c_rmax;
        if (c_phase == '0) begin
            if (s_l < c_lmin) u_lmin = s_l;
            if (s_r < c_rmin) u_rmin = s_r;
            if (s_l > signed'({1'b0, c_lmax})) u_lmax = s_l[MAX_W-1:0];
            if (s_r > signed'({1'b0, c_rmax})) u_rmax = s_r[MAX_W-1:0];
        end

        fcnt_inc   = {1'b0, c_fcnt} + 1'b1;
        phase_inc  = {1'b0, c_phase} + 1'b1;
        bucket_inc = {1'b0, c_bucket} + 1'b1;

        n_lmin   = c_lmin;
        n_rmin   = c_rmin;
        n_lmax   = c_lmax;
        n_rmax   = c_rmax;
        n_fcnt   = c_fcnt;
        n_phase  = c_phase;
        n_bucket = c_bucket;
        n_done   = c_done;
        n_emit   = 1'b0;
        n_last   = 1'b0;
        n_out_data = {2'b00, c_bucket, c_rmax, c_rmin, c_lmax, c_lmin};

        if (!c_done) begin
            if (r_in_eod) begin
                // End of data closes the partial bucket, even an empty one.
                n_emit  = 1'b1;
                n_last  = 1'b1;
                n_done  = 1'b1;
                n_lmin  = '0;
                n_rmin  = '0;
                n_lmax  = '0;
                n_rmax  = '0;
                n_fcnt  = '0;
                n_phase = '0;
            end else if (fcnt_inc >= {1'b0, r_size}) begin
                n_emit     = 1'b1;
                n_last     = bucket_inc >= {1'b0, eff_bpv};
                n_out_data = {2'b00, c_bucket, u_rmax, u_rmin, u_lmax, u_lmin};
                n_bucket   = bucket_inc[BUCKET_W-1:0];
                n_done     = n_last;
                n_lmin     = '0;
                n_rmin     = '0;
                n_lmax     = '0;
                n_rmax     = '0;
                n_fcnt     = '0;
                n_phase    = '0;
            end else begin
                n_lmin  = u_lmin;
                n_rmin  = u_rmin;
                n_lmax  = u_lmax;
                n_rmax  = u_rmax;
                n_fcnt  = fcnt_inc[FCNT_W-1:0];
                n_phase = (phase_inc == {1'b0, eff_stride}) ? '0 : phase_inc[STRIDE_W-1:0];
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_in_valid <= 1'b1;
                r_in_l     <= i_s_tdata[SAMPLE_W-1:0];
                r_in_r     <= i_s_tdata[2*SAMPLE_W-1:SAMPLE_W];
                r_in_start <= i_s_tuser[0];
                r_in_eod   <= i_s_tuser[1];
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    // Envelope state. The phase is also reloaded when the remainder unit ends.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lmin   <= '0;
            r_rmin   <= '0;
            r_lmax   <= '0;
            r_rmax   <= '0;
            r_fcnt   <= '0;
            r_phase  <= '0;
            r_bucket <= '0;
            r_done   <= 1'b0;
        end else if (fire) begin
            r_lmin   <= n_lmin;
            r_rmin   <= n_rmin;
            r_lmax   <= n_lmax;
            r_rmax   <= n_rmax;
            r_fcnt   <= n_fcnt;
            r_phase  <= n_phase;
            r_bucket <= n_bucket;
            r_done   <= n_done;
        end else if (mod_stat.done) begin
            r_phase <= mod_rem;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= fire && n_emit;
            if (fire && n_emit) begin
                r_out_data <= n_out_data;
                r_out_last <= n_last;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

### rtl/core/smme_mod.sv
// ----------------------------------------------------------------------------
// smme_mod: bit-serial remainder unit
// Computes dividend modulo divisor, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module smme_mod (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [smme_pkg::FCNT_W-1:0]      i_dividend,
    input  logic [smme_pkg::STRIDE_W-1:0]    i_divisor,
    output smme_pkg::t_mod_stat              o_stat,
    output logic [smme_pkg::STRIDE_W-1:0]    o_rem
);
    import smme_pkg::*;

    localparam int CNT_W = $clog2(FCNT_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [FCNT_W-1:0]   r_dvd;
    logic [STRIDE_W-1:0] r_dvs;
    logic [STRIDE_W-1:0] r_rem;
    logic [STRIDE_W:0]   n_trial;
    logic [STRIDE_W-1:0] n_rem;

    // The partial remainder stays below the divisor, so the trial fits one extra bit.
    always_comb begin
        n_trial = {r_rem, r_dvd[FCNT_W-1]};
        if (n_trial >= {1'b0, r_dvs}) begin
            n_rem = STRIDE_W'(n_trial - {1'b0, r_dvs});
        end else begin
            n_rem = n_trial[STRIDE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[FCNT_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(FCNT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule
